FILE: sv/gcbf_pkg.sv
`timescale 1ns / 1ps
package gcbf_pkg;

    // Field widths
    localparam int COORD_BITS = 16;
    localparam int Y_BITS     = 15;
    localparam int WRAP_BITS  = 15;

    // Stream packing: query_x, query_y, point_x, point_y, padded to bytes
    localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 2 * Y_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS = 3;
    localparam int IN_DATA_BITS  = 8;

    localparam logic [WRAP_BITS-1:0] WRAP_HALF_RESET = WRAP_BITS'(18000);

    typedef logic signed [COORD_BITS-1:0] t_x;
    typedef logic signed [Y_BITS-1:0]     t_y;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_UP    = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_ANSWER = 1'b1
    } t_cmd;

    typedef enum logic {
        PH_SIDE  = 1'b0,
        PH_AHEAD = 1'b1
    } t_phase;

    typedef enum logic [1:0] {
        REG_START_X      = 2'd0,
        REG_START_Y      = 2'd1,
        REG_START_FACING = 2'd2,
        REG_WRAP_HALF    = 2'd3
    } t_reg;

    typedef struct packed {
        t_x                   start_x;
        t_y                   start_y;
        t_dir                 start_facing;
        logic [WRAP_BITS-1:0] wrap_half;
    } t_cfg;

    typedef struct packed {
        t_x     x;
        t_y     y;
        t_dir   facing;
        t_phase phase;
        logic   busy;
    } t_walk;

    typedef struct packed {
        logic qv;
        logic pv;
        logic done;
        t_x   qx;
        t_y   qy;
        t_x   px;
        t_y   py;
    } t_result;

    // Neighbor pixel in direction d
    function automatic t_x nbr_x(t_x x, t_dir d);
        unique case (d)
            DIR_RIGHT: nbr_x = x + t_x'(1);
            DIR_LEFT:  nbr_x = x - t_x'(1);
            default:   nbr_x = x;
        endcase
    endfunction

    function automatic t_y nbr_y(t_y y, t_dir d);
        unique case (d)
            DIR_UP:   nbr_y = y - t_y'(1);
            DIR_DOWN: nbr_y = y + t_y'(1);
            default:  nbr_y = y;
        endcase
    endfunction

endpackage

FILE: sv/gcbf_step.sv
`timescale 1ns / 1ps
module gcbf_step
    import gcbf_pkg::*;
(
    input  t_walk   i_walk,
    input  t_cfg    i_cfg,
    input  t_cmd    i_cmd,
    input  logic    i_inside,
    output t_walk   o_walk,
    output t_result o_result
);

    t_walk                       nw;
    t_result                     res;
    t_x                          step_x;
    t_x                          two_w;
    logic signed [COORD_BITS+1:0] wide_x;
    logic signed [COORD_BITS+1:0] wide_w;
    logic signed [COORD_BITS+1:0] low_sum;
    logic                        wrap_up;
    logic                        wrap_dn;
    logic                        at_start;

    // Longitude wrap of the stepped column
    always_comb begin
        step_x  = nbr_x(i_walk.x, i_walk.facing);
        two_w   = t_x'({i_cfg.wrap_half, 1'b0});
        wide_x  = (COORD_BITS+2)'(step_x);
        wide_w  = signed'((COORD_BITS+2)'(i_cfg.wrap_half));
        low_sum = wide_x + wide_w;
        wrap_up = (low_sum <= 0);
        wrap_dn = (wide_x > wide_w);
    end

    // One walk step per item
    always_comb begin
        nw       = i_walk;
        res      = '0;
        at_start = 1'b0;
        if (i_cmd == CMD_START) begin
            nw.x      = i_cfg.start_x;
            nw.y      = i_cfg.start_y;
            nw.facing = i_cfg.start_facing;
            nw.phase  = PH_SIDE;
            nw.busy   = 1'b1;
            res.qv    = 1'b1;
            res.qx    = nbr_x(i_cfg.start_x, t_dir'(i_cfg.start_facing + 2'd1));
            res.qy    = nbr_y(i_cfg.start_y, t_dir'(i_cfg.start_facing + 2'd1));
        end else if (i_walk.busy) begin
            if (i_walk.phase == PH_SIDE) begin
                // side test: turn left on a hit
                if (i_inside) begin
                    res.pv    = 1'b1;
                    res.px    = i_walk.x + t_x'((i_walk.facing == DIR_LEFT ||
                                                 i_walk.facing == DIR_DOWN) ? 1 : 0);
                    res.py    = i_walk.y + t_y'((i_walk.facing == DIR_UP) ? 1 : 0);
                    nw.facing = t_dir'(i_walk.facing + 2'd1);
                end
                nw.phase = PH_AHEAD;
                res.qv   = 1'b1;
                res.qx   = nbr_x(i_walk.x, nw.facing);
                res.qy   = nbr_y(i_walk.y, nw.facing);
            end else begin
                // ahead test: turn right when blocked, else step
                if (!i_inside) begin
                    res.pv    = 1'b1;
                    res.px    = i_walk.x + t_x'((i_walk.facing == DIR_RIGHT ||
                                                 i_walk.facing == DIR_DOWN) ? 1 : 0);
                    res.py    = i_walk.y + t_y'((i_walk.facing == DIR_LEFT) ? 1 : 0);
                    nw.facing = t_dir'(i_walk.facing + 2'd3);
                end else begin
                    nw.y = nbr_y(i_walk.y, i_walk.facing);
                    if (wrap_up) begin
                        nw.x = step_x + two_w;
                    end else if (wrap_dn) begin
                        nw.x = step_x - two_w;
                    end else begin
                        nw.x = step_x;
                    end
                end
                nw.phase = PH_SIDE;
                at_start = (nw.x == i_cfg.start_x) && (nw.y == i_cfg.start_y) &&
                           (nw.facing == i_cfg.start_facing);
                if (at_start) begin
                    nw.busy  = 1'b0;
                    res.done = 1'b1;
                end else begin
                    res.qv = 1'b1;
                    res.qx = nbr_x(nw.x, t_dir'(nw.facing + 2'd1));
                    res.qy = nbr_y(nw.y, t_dir'(nw.facing + 2'd1));
                end
            end
        end
        o_walk   = nw;
        o_result = res;
    end

endmodule

FILE: sv/grid_contour_boundary_follower_top.sv
`timescale 1ns / 1ps
// A result item appears on the master side in the cycle after its item is taken.
// Throughput: one item per cycle unless the master stalls; the walk state updates in the
// accepting cycle; the result sits in one output register, refilled in the cycle it is taken.
// Reset (i_rst_n low, synchronous): walker idle, output empty, registers at
// start 0/0, facing right, wrap_half 18000.
module grid_contour_boundary_follower_top
    import gcbf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // slave side
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,   // [0] inside_req, rest zero
    input  logic                     i_s_tuser,   // [0] command
    // master side
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,   // query_x, query_y, point_x, point_y, zeros
    output logic [OUT_USER_BITS-1:0] o_m_tuser,   // [0] query_valid, [1] point_valid, [2] done_res
    // configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [COORD_BITS-1:0]    i_cfg_data
);

    t_cfg    r_cfg;
    t_walk   r_walk;
    t_walk   n_walk;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    s_take;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign s_take      = i_s_tvalid && o_s_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_x      <= '0;
            r_cfg.start_y      <= '0;
            r_cfg.start_facing <= DIR_RIGHT;
            r_cfg.wrap_half    <= WRAP_HALF_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_START_X:      r_cfg.start_x      <= t_x'(i_cfg_data);
                REG_START_Y:      r_cfg.start_y      <= t_y'(i_cfg_data[Y_BITS-1:0]);
                REG_START_FACING: r_cfg.start_facing <= t_dir'(i_cfg_data[1:0]);
                REG_WRAP_HALF:    r_cfg.wrap_half    <= i_cfg_data[WRAP_BITS-1:0];
                default:          r_cfg.start_x      <= r_cfg.start_x;
            endcase
        end
    end

    // Walk step logic
    gcbf_step u_step (
        .i_walk   (r_walk),
        .i_cfg    (r_cfg),
        .i_cmd    (t_cmd'(i_s_tuser)),
        .i_inside (i_s_tdata[0]),
        .o_walk   (n_walk),
        .o_result (n_out)
    );

    // Walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk.x      <= '0;
            r_walk.y      <= '0;
            r_walk.facing <= DIR_RIGHT;
            r_walk.phase  <= PH_SIDE;
            r_walk.busy   <= 1'b0;
        end else if (s_take) begin
            r_walk <= n_walk;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_BITS'({r_out.py, r_out.px, r_out.qy, r_out.qx});
    assign o_m_tuser  = {r_out.done, r_out.pv, r_out.qv};

endmodule

FILE: sv/gcbf_checker.sv
`timescale 1ns / 1ps
module gcbf_checker
    import gcbf_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_tvalid,
    input logic                     o_s_tready,
    input logic                     i_s_tuser,
    input logic                     o_m_tvalid,
    input logic                     i_m_tready,
    input logic [OUT_DATA_BITS-1:0] o_m_tdata,
    input logic [OUT_USER_BITS-1:0] o_m_tuser
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // every accepted item yields a result next cycle
    a_item_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted item gave no result");

    // a start gives a bare query
    a_start_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (t_cmd'(i_s_tuser) == CMD_START) |=> o_m_tuser == 3'b001)
        else $error("start result not a plain query");

    // done never comes with a pending query
    a_done_no_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2] |-> !o_m_tuser[0])
        else $error("done with query pending");

endmodule

bind grid_contour_boundary_follower_top gcbf_checker u_gcbf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: bench/tb_grid_contour_boundary_follower_top.sv
`timescale 1ns / 1ps
module tb_grid_contour_boundary_follower_top;
    import gcbf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int NRECT       = 3;

    // Walker model plus the queue of result items still owed by the block
    class walk_scoreboard;
        t_x                   cfg_x;
        t_y                   cfg_y;
        logic [1:0]           cfg_facing;
        logic [WRAP_BITS-1:0] cfg_wrap;
        t_x                   pos_x;
        t_y                   pos_y;
        logic [1:0]           heading;
        t_phase               phase;
        bit                   busy;
        t_result              last_out;
        t_result              owed_results[$];
        int errors, n_in, n_starts, n_done, n_points, n_ignored;

        function new();
            cfg_x      = '0;
            cfg_y      = '0;
            cfg_facing = DIR_RIGHT;
            cfg_wrap   = WRAP_HALF_RESET;
            pos_x      = '0;
            pos_y      = '0;
            heading    = DIR_RIGHT;
            phase      = PH_SIDE;
            busy       = 1'b0;
            last_out   = '0;
        endfunction

        function void write_cfg(t_reg idx, logic [COORD_BITS-1:0] v);
            case (idx)
                REG_START_X:      cfg_x      = t_x'(v);
                REG_START_Y:      cfg_y      = v[Y_BITS-1:0];
                REG_START_FACING: cfg_facing = v[1:0];
                REG_WRAP_HALF:    cfg_wrap   = v[WRAP_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Neighbor of the current pixel in direction d
        function t_x look_x(logic [1:0] d);
            case (d)
                DIR_RIGHT: return pos_x + t_x'(1);
                DIR_LEFT:  return pos_x - t_x'(1);
                default:   return pos_x;
            endcase
        endfunction

        function t_y look_y(logic [1:0] d);
            case (d)
                DIR_UP:   return pos_y - t_y'(1);
                DIR_DOWN: return pos_y + t_y'(1);
                default:  return pos_y;
            endcase
        endfunction

        // One walker step for one accepted item
        function t_result advance_walker(t_cmd cmd, logic is_in);
            t_result r;
            int nx, w;
            r = '0;
            if (cmd == CMD_START) begin
                pos_x   = cfg_x;
                pos_y   = cfg_y;
                heading = cfg_facing;
                phase   = PH_SIDE;
                busy    = 1'b1;
                r.qv    = 1'b1;
                r.qx    = look_x(heading + 2'd1);
                r.qy    = look_y(heading + 2'd1);
                n_starts++;
            end else if (!busy) begin
                n_ignored++;
            end else if (phase == PH_SIDE) begin
                // left pixel inside: corner, turn toward it
                if (is_in) begin
                    r.pv = 1'b1;
                    r.px = pos_x + ((heading == DIR_RIGHT || heading == DIR_UP) ?
                                    t_x'(0) : t_x'(1));
                    r.py = pos_y + ((heading == DIR_UP) ? t_y'(1) : t_y'(0));
                    heading = heading + 2'd1;
                end
                phase = PH_AHEAD;
                r.qv  = 1'b1;
                r.qx  = look_x(heading);
                r.qy  = look_y(heading);
            end else begin
                if (!is_in) begin
                    // blocked ahead: corner, turn right
                    r.pv = 1'b1;
                    r.px = pos_x + ((heading == DIR_RIGHT || heading == DIR_DOWN) ?
                                    t_x'(1) : t_x'(0));
                    r.py = pos_y + ((heading == DIR_LEFT) ? t_y'(1) : t_y'(0));
                    heading = heading - 2'd1;
                end else begin
                    // step forward, then longitude wrap once
                    w     = cfg_wrap;
                    nx    = look_x(heading);
                    pos_y = look_y(heading);
                    if (nx <= -w)
                        nx += 2 * w;
                    else if (nx > w)
                        nx -= 2 * w;
                    pos_x = t_x'(nx);
                end
                phase = PH_SIDE;
                if (pos_x == cfg_x && pos_y == cfg_y && heading == cfg_facing) begin
                    busy   = 1'b0;
                    r.done = 1'b1;
                    n_done++;
                end else begin
                    r.qv = 1'b1;
                    r.qx = look_x(heading + 2'd1);
                    r.qy = look_y(heading + 2'd1);
                end
            end
            if (r.pv)
                n_points++;
            return r;
        endfunction

        function void note_item(t_cmd cmd, logic is_in);
            last_out = advance_walker(cmd, is_in);
            owed_results.push_back(last_out);
            n_in++;
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH %s: got %0d, expected %0d (after %0d items)",
                     what, got, want, n_in);
            errors++;
        endtask

        task check_item(input logic [OUT_DATA_BITS-1:0] d,
                        input logic [OUT_USER_BITS-1:0] u);
            t_result want, got;
            if (owed_results.size() == 0) begin
                report_mismatch("result item with nothing owed", 1, 0);
            end else begin
                want     = owed_results.pop_front();
                got.qx   = d[COORD_BITS-1:0];
                got.qy   = d[COORD_BITS +: Y_BITS];
                got.px   = d[COORD_BITS+Y_BITS +: COORD_BITS];
                got.py   = d[2*COORD_BITS+Y_BITS +: Y_BITS];
                got.qv   = u[0];
                got.pv   = u[1];
                got.done = u[2];
                if (got.qv !== want.qv)     report_mismatch("query_valid", got.qv, want.qv);
                if (got.qx !== want.qx)     report_mismatch("query_x", got.qx, want.qx);
                if (got.qy !== want.qy)     report_mismatch("query_y", got.qy, want.qy);
                if (got.pv !== want.pv)     report_mismatch("point_valid", got.pv, want.pv);
                if (got.px !== want.px)     report_mismatch("point_x", got.px, want.px);
                if (got.py !== want.py)     report_mismatch("point_y", got.py, want.py);
                if (got.done !== want.done) report_mismatch("done_res", got.done, want.done);
            end
        endtask

        task finish_check();
            if (owed_results.size() != 0)
                report_mismatch("result items never delivered", 0, owed_results.size());
        endtask
    endclass

    logic                     i_clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [OUT_USER_BITS-1:0] m_tuser;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [1:0]               cfg_index;
    logic [COORD_BITS-1:0]    cfg_data;

    walk_scoreboard sb;
    bit             calm = 1'b0;
    int             cycle_count = 0;

    // Inside/outside oracle: union of rectangles, optional random flips
    int rx0[NRECT], rx1[NRECT], ry0[NRECT], ry1[NRECT];
    int noise_pct = 0;

    grid_contour_boundary_follower_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side back-pressure
    always @(negedge i_clk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_item(m_tdata, m_tuser);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic oracle(t_x qx, t_y qy);
        int x, y;
        logic hit;
        x   = qx;
        y   = qy;
        hit = 1'b0;
        for (int i = 0; i < NRECT; i++)
            if (x >= rx0[i] && x <= rx1[i] && y >= ry0[i] && y <= ry1[i])
                hit = 1'b1;
        if (noise_pct > 0 && $urandom_range(99) < noise_pct)
            hit = ~hit;
        return hit;
    endfunction

    task set_rect(int i, int x0, int x1, int y0, int y1);
        rx0[i] = x0;
        rx1[i] = x1;
        ry0[i] = y0;
        ry1[i] = y1;
    endtask

    // Random blob of one to three rectangles, the first covering the start pixel
    task make_shape();
        int cx, cy, bx, by, nrect;
        cx    = sb.cfg_x;
        cy    = sb.cfg_y;
        nrect = $urandom_range(1, NRECT);
        for (int i = 0; i < NRECT; i++) begin
            if (i < nrect) begin
                bx = (i == 0) ? cx : cx + int'($urandom_range(0, 6)) - 3;
                by = (i == 0) ? cy : cy + int'($urandom_range(0, 6)) - 3;
                set_rect(i, bx - int'($urandom_range(0, 3)), bx + int'($urandom_range(0, 3)),
                         by - int'($urandom_range(0, 3)), by + int'($urandom_range(0, 3)));
            end else begin
                set_rect(i, 1, 0, 1, 0);
            end
        end
        noise_pct = ($urandom_range(9) == 0) ? 25 : 0;
    endtask

    // Send one item; entered and left at a falling edge
    task send_item(t_cmd cmd, logic is_in);
        while (!calm && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_DATA_BITS-1){1'b0}}, is_in};
        do @(posedge i_clk); while (!s_tready);
        sb.note_item(cmd, is_in);
        @(negedge i_clk);
    endtask

    task write_reg(t_reg idx, logic [COORD_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        sb.write_cfg(idx, val);
        @(negedge i_clk);
    endtask

    task write_config(int sx, int sy, int sf, int wh, logic [3:0] wmask);
        if (wmask[0]) write_reg(REG_START_X, COORD_BITS'(sx));
        if (wmask[1]) write_reg(REG_START_Y, COORD_BITS'(sy));
        if (wmask[2]) write_reg(REG_START_FACING, COORD_BITS'(sf));
        if (wmask[3]) write_reg(REG_WRAP_HALF, COORD_BITS'(wh));
        cfg_valid <= 1'b0;
    endtask

    // Wait until every owed result item has come back
    task wait_drain();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.owed_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Start, then answer queries from the oracle until closed or capped
    task run_trace(input int cap, input bit fresh, output int used);
        int n;
        if (fresh)
            make_shape();
        send_item(CMD_START, 1'($urandom_range(1)));
        n = 0;
        while (sb.busy && n < cap) begin
            send_item(CMD_ANSWER, oracle(sb.last_out.qx, sb.last_out.qy));
            n++;
        end
        used = n + 1;
        // stray answer after the walk has closed
        if (!sb.busy && $urandom_range(3) == 0)
            send_item(CMD_ANSWER, 1'($urandom_range(1)));
    endtask

    initial begin
        int used, budget, cap;
        int sx, sy, sf, wh;
        logic [3:0] wmask;

        sb        = new();
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_START;
        cfg_valid <= 1'b0;
        cfg_index <= REG_START_X;
        cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Directed: answers while idle, an L shape cut short, then a lone pixel
        // whose start restarts the busy walker and closes after four right turns
        send_item(CMD_ANSWER, 1'b0);
        send_item(CMD_ANSWER, 1'b1);
        noise_pct = 0;
        set_rect(0, 0, 2, 0, 0);
        set_rect(1, 0, 0, 0, 2);
        set_rect(2, 1, 0, 1, 0);
        run_trace(14, 1'b0, used);
        set_rect(0, 0, 0, 0, 0);
        set_rect(1, 1, 0, 1, 0);
        run_trace(12, 1'b0, used);
        send_item(CMD_ANSWER, 1'b1);

        // Random traces under several register settings
        for (int ph = 1; ph <= 9; ph++) begin
            wait_drain();
            case (ph)
                1: begin sx = -18000; sy = -9000; sf = DIR_RIGHT; wh = 18000; wmask = 4'hF; end
                2: begin sx = 18000;  sy = 9000;  sf = DIR_LEFT;  wh = 18000; wmask = 4'hF; end
                3: begin sx = 17999;  sy = -8999; sf = DIR_UP;    wh = 1;     wmask = 4'hF; end
                4: begin sx = 0;      sy = 0;     sf = DIR_DOWN;  wh = 2;     wmask = 4'hF; end
                default: begin
                    sx    = int'($urandom_range(0, 36000)) - 18000;
                    sy    = int'($urandom_range(0, 18000)) - 9000;
                    sf    = $urandom_range(3);
                    wh    = $urandom_range(1) ? $urandom_range(1, 6) : $urandom_range(1, 18000);
                    wmask = 4'($urandom_range(1, 15));
                end
            endcase
            write_config(sx, sy, sf, wh, wmask);
            calm   = (ph == 3 || ph == 4);
            budget = 85;
            while (budget > 0) begin
                cap = ($urandom_range(9) == 0) ? $urandom_range(1, 8) : 60;
                if (cap > budget)
                    cap = budget;
                run_trace(cap, 1'b1, used);
                budget -= used;
            end
        end

        wait_drain();
        repeat (4) @(posedge i_clk);
        sb.finish_check();
        $display("Covered %0d items: %0d traces started, %0d closed, %0d corner points,",
                 sb.n_in, sb.n_starts, sb.n_done, sb.n_points);
        $display("%0d answers while idle, register settings from both coordinate extremes",
                 sb.n_ignored);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
